FILE: rtl/core/rvar_pkg.sv
package rvar_pkg;

    localparam int TERM_W         = 31;
    localparam int ID_W           = 4;
    localparam int CNT_W          = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int LOG_DEPTH_DEF  = 1024;
    localparam int MAX_BATCH_DEF  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_TERM  = 1'b1;

    localparam logic KIND_VOTE   = 1'b0;
    localparam logic KIND_APPEND = 1'b1;

    localparam logic signed [31:0] CTERM_NONE = -32'sd1;
    localparam logic [TERM_W-1:0]  IDX_MAX    = {TERM_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_VOTE  = 2'd0,
        MODE_HDR   = 2'd1,
        MODE_ENTRY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [TERM_W-1:0]  msg_term;
        logic [ID_W-1:0]    sender_id;
        logic [TERM_W-1:0]  log_index;
        logic [TERM_W-1:0]  log_term;
        logic [TERM_W-1:0]  leader_commit;
        logic [CNT_W-1:0]   entry_count;
        logic [TERM_W-1:0]  entry_term;
    } t_in_item;

    typedef struct packed {
        logic               reply_kind;
        logic [TERM_W-1:0]  reply_term;
        logic               accepted;
        logic signed [31:0] conflict_term;
        logic [TERM_W-1:0]  conflict_index;
        logic [TERM_W-1:0]  log_end;
        logic               timer_reset;
        logic               persist_needed;
        logic [TERM_W-1:0]  commit_index;
        logic               overflow;
    } t_out_item;

    function automatic logic [TERM_W-1:0] sat31(input logic [31:0] v);
        sat31 = v[31] ? IDX_MAX : v[TERM_W-1:0];
    endfunction

    function automatic t_out_item mk_reply(
        input logic               kind,
        input logic [TERM_W-1:0]  term,
        input logic               acc,
        input logic signed [31:0] cterm,
        input logic [TERM_W-1:0]  cidx,
        input logic [TERM_W-1:0]  lend,
        input logic               timer,
        input logic               persist,
        input logic [TERM_W-1:0]  commit,
        input logic               ovf
    );
        t_out_item r;
        r.reply_kind     = kind;
        r.reply_term     = term;
        r.accepted       = acc;
        r.conflict_term  = cterm;
        r.conflict_index = cidx;
        r.log_end        = lend;
        r.timer_reset    = timer;
        r.persist_needed = persist;
        r.commit_index   = commit;
        r.overflow       = ovf;
        mk_reply = r;
    endfunction

endpackage

FILE: rtl/core/rvar_in_if.sv
interface rvar_in_if;
    import rvar_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/rvar_out_if.sv
interface rvar_out_if;
    import rvar_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/rvar_store.sv
module rvar_store #(
    parameter int LOG_DEPTH = rvar_pkg::LOG_DEPTH_DEF,
    localparam int AW = $clog2(LOG_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [rvar_pkg::TERM_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [rvar_pkg::TERM_W-1:0] i_wr_data
);
    import rvar_pkg::*;

    logic [TERM_W-1:0] mem [LOG_DEPTH];
    logic [TERM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/rvar_ctrl.sv
module rvar_ctrl #(
    parameter int LOG_DEPTH = rvar_pkg::LOG_DEPTH_DEF,
    parameter int MAX_BATCH = rvar_pkg::MAX_BATCH_DEF,
    localparam int AW = $clog2(LOG_DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rvar_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rvar_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [rvar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rvar_pkg::TERM_W-1:0]    i_cfg_data,
    output logic                           o_rd_en,
    output logic [AW-1:0]                  o_rd_addr,
    input  logic [rvar_pkg::TERM_W-1:0]    i_rd_data,
    output logic                           o_wr_en,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [rvar_pkg::TERM_W-1:0]    o_wr_data
);
    import rvar_pkg::*;

    localparam int SLW = AW + 1;
    localparam int ELW = $clog2(MAX_BATCH + 1);

    t_state            r_state, n_state;
    logic [TERM_W-1:0] r_base_index, n_base_index;
    logic [TERM_W-1:0] r_base_term, n_base_term;
    logic [TERM_W-1:0] r_term, n_term;
    logic              r_vote_valid, n_vote_valid;
    logic [ID_W-1:0]   r_voted_id, n_voted_id;
    logic [SLW-1:0]    r_len, n_len;
    logic [TERM_W-1:0] r_committed, n_committed;
    logic [ELW-1:0]    r_left, n_left;
    logic              r_append_ok, n_append_ok;
    logic [SLW-1:0]    r_next, n_next;
    logic [TERM_W-1:0] r_pending, n_pending;
    t_in_item          r_in, n_in;
    logic [TERM_W-1:0] r_walk, n_walk;
    logic              r_first, n_first;
    logic [TERM_W-1:0] r_cterm, n_cterm;
    logic              r_persist, n_persist;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              go;
    logic              newer;
    logic              can_vote;
    logic              up_to_date;
    logic              match;
    logic              walk_on;
    logic              ovf;
    logic [TERM_W-1:0] lterm;
    logic [TERM_W-1:0] tpos;
    logic [TERM_W-1:0] tw;
    logic [TERM_W-1:0] pos;
    logic [TERM_W-1:0] nc;
    logic [ELW-1:0]    clamp;
    logic [31:0]       lidx;
    logic [31:0]       log_end;
    logic [31:0]       last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_base_index <= '0;
            r_base_term  <= '0;
            r_term       <= '0;
            r_vote_valid <= 1'b0;
            r_voted_id   <= '0;
            r_len        <= SLW'(1);
            r_committed  <= '0;
            r_left       <= '0;
            r_append_ok  <= 1'b0;
            r_next       <= '0;
            r_pending    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_base_index <= n_base_index;
            r_base_term  <= n_base_term;
            r_term       <= n_term;
            r_vote_valid <= n_vote_valid;
            r_voted_id   <= n_voted_id;
            r_len        <= n_len;
            r_committed  <= n_committed;
            r_left       <= n_left;
            r_append_ok  <= n_append_ok;
            r_next       <= n_next;
            r_pending    <= n_pending;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_walk    <= n_walk;
        r_first   <= n_first;
        r_cterm   <= n_cterm;
        r_persist <= n_persist;
        r_out     <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_base_index = r_base_index;
        n_base_term  = r_base_term;
        n_term       = r_term;
        n_vote_valid = r_vote_valid;
        n_voted_id   = r_voted_id;
        n_len        = r_len;
        n_committed  = r_committed;
        n_left       = r_left;
        n_append_ok  = r_append_ok;
        n_next       = r_next;
        n_pending    = r_pending;
        n_in         = r_in;
        n_walk       = r_walk;
        n_first      = r_first;
        n_cterm      = r_cterm;
        n_persist    = r_persist;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = r_in.entry_term;

        go      = !r_out_valid || i_out_ready;
        newer   = r_in.msg_term > r_term;
        log_end = {1'b0, r_base_index} + 32'(r_len);
        lidx    = log_end - 32'd1;
        last    = log_end - 32'd1;
        lterm   = (r_len == SLW'(1)) ? r_base_term : i_rd_data;
        up_to_date = (r_in.log_term > lterm) ||
                     ((r_in.log_term == lterm) && ({1'b0, r_in.log_index} >= lidx));
        can_vote = !r_vote_valid || newer || (r_voted_id == r_in.sender_id);
        pos     = r_in.log_index - r_base_index;
        tpos    = (pos == '0) ? r_base_term : i_rd_data;
        clamp   = (32'(r_in.entry_count) > 32'(MAX_BATCH)) ? ELW'(MAX_BATCH)
                                                          : ELW'(r_in.entry_count);
        tw      = (r_walk == r_base_index) ? r_base_term : i_rd_data;
        match   = r_first || (tw == r_cterm);
        walk_on = (r_walk > r_committed) && (r_walk >= r_base_index) && match;
        nc      = ({1'b0, r_pending} < last) ? r_pending : last[TERM_W-1:0];
        ovf     = 32'(r_next) > 32'(LOG_DEPTH);

        if (i_cfg_we) begin
            if (i_cfg_idx == REG_BASE_INDEX) begin
                n_base_index = i_cfg_data;
            end else begin
                n_base_term = i_cfg_data;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    o_rd_en = 1'b1;
                    case (i_in_data.mode)
                        MODE_VOTE: o_rd_addr = AW'(r_len - SLW'(1));
                        MODE_HDR:  o_rd_addr = AW'(i_in_data.log_index - r_base_index);
                        default:   o_rd_addr = AW'(r_next);
                    endcase
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (go) begin
                    n_state = S_IDLE;
                    case (r_in.mode)
                        MODE_VOTE: begin
                            n_left      = '0;
                            n_append_ok = 1'b0;
                            if (r_in.msg_term < r_term) begin
                                n_out_valid = 1'b1;
                                n_out = mk_reply(KIND_VOTE, r_term, 1'b0, '0, '0, '0,
                                                 1'b0, 1'b0, r_committed, 1'b0);
                            end else begin
                                if (newer) begin
                                    n_term       = r_in.msg_term;
                                    n_vote_valid = 1'b0;
                                end
                                n_out_valid = 1'b1;
                                if (can_vote && up_to_date) begin
                                    n_vote_valid = 1'b1;
                                    n_voted_id   = r_in.sender_id;
                                    n_out = mk_reply(KIND_VOTE, n_term, 1'b1, '0, '0, '0,
                                                     1'b1, 1'b1, r_committed, 1'b0);
                                end else begin
                                    n_out = mk_reply(KIND_VOTE, n_term, 1'b0, '0, '0, '0,
                                                     1'b0, newer, r_committed, 1'b0);
                                end
                            end
                        end
                        MODE_HDR: begin
                            n_left      = clamp;
                            n_append_ok = 1'b0;
                            if (r_in.msg_term < r_term) begin
                                n_out_valid = 1'b1;
                                n_out = mk_reply(KIND_APPEND, r_term, 1'b0, '0, '0, '0,
                                                 1'b0, 1'b0, r_committed, 1'b0);
                            end else begin
                                if (newer) begin
                                    n_term       = r_in.msg_term;
                                    n_vote_valid = 1'b0;
                                end
                                if (r_in.log_index < r_base_index) begin
                                    n_out_valid = 1'b1;
                                    n_out = mk_reply(KIND_APPEND, n_term, 1'b1, '0, '0, '0,
                                                     1'b1, newer, r_committed, 1'b0);
                                end else if ({1'b0, r_in.log_index} >= log_end) begin
                                    n_out_valid = 1'b1;
                                    n_out = mk_reply(KIND_APPEND, n_term, 1'b0, CTERM_NONE,
                                                     '0, sat31(log_end), 1'b1, newer,
                                                     r_committed, 1'b0);
                                end else if (tpos != r_in.log_term) begin
                                    n_walk    = r_in.log_index;
                                    n_first   = 1'b1;
                                    n_cterm   = tpos;
                                    n_persist = newer;
                                    n_state   = S_WALK;
                                end else begin
                                    n_append_ok = 1'b1;
                                    n_next      = SLW'(pos) + SLW'(1);
                                    n_pending   = r_in.leader_commit;
                                    if (clamp == '0) begin
                                        n_state = S_FIN;
                                    end
                                end
                            end
                        end
                        MODE_ENTRY: begin
                            if (r_left != '0) begin
                                n_left = r_left - ELW'(1);
                                if (r_append_ok) begin
                                    if ((r_next != '0) && (32'(r_next) < 32'(LOG_DEPTH))) begin
                                        if (r_next < r_len) begin
                                            if (i_rd_data != r_in.entry_term) begin
                                                o_wr_en   = 1'b1;
                                                o_wr_addr = AW'(r_next);
                                                n_len     = r_next + SLW'(1);
                                            end
                                        end else if (r_next == r_len) begin
                                            o_wr_en   = 1'b1;
                                            o_wr_addr = AW'(r_next);
                                            n_len     = r_next + SLW'(1);
                                        end
                                    end
                                    if (!ovf) begin
                                        n_next = r_next + SLW'(1);
                                    end
                                    if (r_left == ELW'(1)) begin
                                        n_state = S_FIN;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (go) begin
                    if (walk_on) begin
                        n_walk    = r_walk - TERM_W'(1);
                        n_first   = 1'b0;
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(r_walk - TERM_W'(1) - r_base_index);
                    end else begin
                        n_out_valid = 1'b1;
                        n_out = mk_reply(KIND_APPEND, r_term, 1'b0, {1'b0, r_cterm},
                                         sat31({1'b0, r_walk} + 32'd1), sat31(log_end),
                                         1'b1, r_persist, r_committed, 1'b0);
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (go) begin
                    if (nc > r_committed) begin
                        n_committed = nc;
                    end
                    n_append_ok = 1'b0;
                    n_out_valid = 1'b1;
                    if (ovf) begin
                        n_out = mk_reply(KIND_APPEND, r_term, 1'b0, CTERM_NONE, '0,
                                         sat31(log_end), 1'b1, 1'b1, n_committed, 1'b1);
                    end else begin
                        n_out = mk_reply(KIND_APPEND, r_term, 1'b1, '0, '0, '0,
                                         1'b1, 1'b1, n_committed, 1'b0);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_wr_in_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_PROC) && (r_in.mode == MODE_ENTRY))
        else $error("store write outside entry handling");

    a_wr_not_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (o_wr_addr != '0))
        else $error("store position zero written");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_len != '0) && (32'(r_len) <= 32'(LOG_DEPTH)))
        else $error("stored length out of range");

    a_commit_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |=> r_committed >= $past(r_committed))
        else $error("commit index decreased");

endmodule

FILE: rtl/core/raft_vote_and_append_receiver.sv
// Channel   Dir  Handshake        Payload
// i_msg     in   valid / ready    rvar_pkg::t_in_item (vote, append header, entry)
// o_reply   out  valid / ready    rvar_pkg::t_out_item (vote or append reply)
// i_cfg_*   in   write enable     snapshot base index / term
//
// An item is accepted (term store read issued), then processed and written
// back. A term conflict walks the store down one index per cycle while no
// reply waits, until the commit or base index or a term change. Header
// success with no entries and the last entry add a commit update state.
// Reset is synchronous; the store is not cleared. A reply waiting in the
// output register stalls processing, not acceptance of the next transaction.
module raft_vote_and_append_receiver #(
    parameter int LOG_DEPTH = rvar_pkg::LOG_DEPTH_DEF,
    parameter int MAX_BATCH = rvar_pkg::MAX_BATCH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rvar_in_if.sink                        i_msg,
    rvar_out_if.source                     o_reply,
    input  logic                           i_cfg_we,
    input  logic [rvar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rvar_pkg::TERM_W-1:0]    i_cfg_data
);
    import rvar_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [TERM_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TERM_W-1:0] wr_data;

    rvar_ctrl #(
        .LOG_DEPTH (LOG_DEPTH),
        .MAX_BATCH (MAX_BATCH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_msg.valid),
        .o_in_ready  (i_msg.ready),
        .i_in_data   (i_msg.data),
        .o_out_valid (o_reply.valid),
        .i_out_ready (o_reply.ready),
        .o_out_data  (o_reply.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    rvar_store #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

FILE: bench/raft_vote_and_append_checker.sv
module raft_vote_and_append_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rvar_in_if                             msg,
    rvar_out_if                            reply,
    input  logic                           i_cfg_we,
    input  logic [rvar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rvar_pkg::TERM_W-1:0]    i_cfg_data,
    output logic [rvar_pkg::TERM_W-1:0]    o_term,
    output logic [rvar_pkg::TERM_W-1:0]    o_last_term,
    output longint                         o_log_end,
    output int                             o_failures,
    output int                             o_pending
);
    import rvar_pkg::*;

    localparam int DEPTH = LOG_DEPTH_DEF;
    localparam int BATCH = MAX_BATCH_DEF;

    logic [TERM_W-1:0] base_idx, base_term;
    logic [TERM_W-1:0] cur_term, commit, pend_commit;
    logic              vote_valid;
    logic [ID_W-1:0]   voted_id;
    logic [TERM_W-1:0] terms [DEPTH];
    int                stored_len, left, slot;
    logic              batch_ok;
    t_out_item         replies_due [$];
    t_out_item         predicted;
    int                failures;

    function automatic logic [TERM_W-1:0] clip(input longint v);
        return (v > longint'(IDX_MAX)) ? IDX_MAX : v[TERM_W-1:0];
    endfunction

    function automatic logic [TERM_W-1:0] term_of(input longint pos);
        if (pos == 0)
            return base_term;
        if (pos < DEPTH)
            return terms[int'(pos)];
        return '0;
    endfunction

    function automatic longint log_end();
        return longint'(base_idx) + longint'(stored_len);
    endfunction

    function automatic t_out_item make(input logic kind, input logic acc,
                                       input logic signed [31:0] cterm,
                                       input longint cidx, input longint lend,
                                       input logic timer, input logic persist,
                                       input logic ovf);
        t_out_item r;
        r.reply_kind     = kind;
        r.reply_term     = cur_term;
        r.accepted       = acc;
        r.conflict_term  = cterm;
        r.conflict_index = clip(cidx);
        r.log_end        = clip(lend);
        r.timer_reset    = timer;
        r.persist_needed = persist;
        r.commit_index   = commit;
        r.overflow       = ovf;
        return r;
    endfunction

    function automatic t_out_item close_batch();
        longint last, nc;
        last = log_end() - 1;
        nc = (longint'(pend_commit) < last) ? longint'(pend_commit) : last;
        if (nc > longint'(commit))
            commit = nc[TERM_W-1:0];
        batch_ok = 0;
        if (slot > DEPTH)
            return make(KIND_APPEND, 1'b0, CTERM_NONE, 0, log_end(), 1'b1, 1'b1, 1'b1);
        return make(KIND_APPEND, 1'b1, '0, 0, 0, 1'b1, 1'b1, 1'b0);
    endfunction

    function automatic bit predict_reply(input t_in_item m, output t_out_item r);
        logic              persist;
        longint            endv, pos, i;
        logic [TERM_W-1:0] t;
        persist = 0;
        r = '0;
        if (m.mode == MODE_NONE)
            return 0;
        if (m.mode == MODE_ENTRY) begin
            if (left == 0)
                return 0;
            left--;
            if (!batch_ok)
                return 0;
            if (slot >= 1 && slot < DEPTH) begin
                if (slot < stored_len) begin
                    if (terms[slot] != m.entry_term) begin
                        terms[slot] = m.entry_term;
                        stored_len = slot + 1;
                    end
                end else if (slot == stored_len) begin
                    terms[slot] = m.entry_term;
                    stored_len = slot + 1;
                end
            end
            if (slot <= DEPTH)
                slot++;
            if (left == 0) begin
                r = close_batch();
                return 1;
            end
            return 0;
        end
        // any new vote or header message drops an open batch
        left = 0;
        batch_ok = 0;
        if (m.mode == MODE_VOTE) begin
            if (m.msg_term < cur_term) begin
                r = make(KIND_VOTE, 1'b0, '0, 0, 0, 1'b0, 1'b0, 1'b0);
                return 1;
            end
            if (m.msg_term > cur_term) begin
                cur_term = m.msg_term;
                vote_valid = 0;
                persist = 1;
            end
            if (!vote_valid || voted_id == m.sender_id) begin
                t = term_of(longint'(stored_len) - 1);
                if (m.log_term > t ||
                    (m.log_term == t && longint'(m.log_index) >= log_end() - 1)) begin
                    vote_valid = 1;
                    voted_id = m.sender_id;
                    r = make(KIND_VOTE, 1'b1, '0, 0, 0, 1'b1, 1'b1, 1'b0);
                    return 1;
                end
            end
            r = make(KIND_VOTE, 1'b0, '0, 0, 0, 1'b0, persist, 1'b0);
            return 1;
        end
        left = (int'(m.entry_count) > BATCH) ? BATCH : int'(m.entry_count);
        if (m.msg_term < cur_term) begin
            r = make(KIND_APPEND, 1'b0, '0, 0, 0, 1'b0, 1'b0, 1'b0);
            return 1;
        end
        if (m.msg_term > cur_term) begin
            cur_term = m.msg_term;
            vote_valid = 0;
            persist = 1;
        end
        endv = log_end();
        if (m.log_index < base_idx) begin
            r = make(KIND_APPEND, 1'b1, '0, 0, 0, 1'b1, persist, 1'b0);
            return 1;
        end
        if (longint'(m.log_index) >= endv) begin
            r = make(KIND_APPEND, 1'b0, CTERM_NONE, 0, endv, 1'b1, persist, 1'b0);
            return 1;
        end
        pos = longint'(m.log_index) - longint'(base_idx);
        t = term_of(pos);
        if (t != m.log_term) begin
            i = longint'(m.log_index);
            while (i > longint'(commit) && i >= longint'(base_idx) &&
                   term_of(i - longint'(base_idx)) == t)
                i--;
            r = make(KIND_APPEND, 1'b0, {1'b0, t}, i + 1, endv, 1'b1, persist, 1'b0);
            return 1;
        end
        batch_ok = 1;
        slot = int'(pos + 1);
        pend_commit = m.leader_commit;
        if (left == 0) begin
            r = close_batch();
            return 1;
        end
        return 0;
    endfunction

    function automatic void field(input string name, input longint e, input longint g);
        if (e != g) begin
            $error("%s expected %0d got %0d", name, e, g);
            failures++;
        end
    endfunction

    task automatic check_reply(input t_out_item got);
        t_out_item e;
        if (replies_due.size() == 0) begin
            $error("unexpected reply transaction: %p", got);
            failures++;
            return;
        end
        e = replies_due.pop_front();
        field("reply_kind", e.reply_kind, got.reply_kind);
        field("reply_term", e.reply_term, got.reply_term);
        field("accepted", e.accepted, got.accepted);
        field("conflict_term", e.conflict_term, got.conflict_term);
        field("conflict_index", e.conflict_index, got.conflict_index);
        field("log_end", e.log_end, got.log_end);
        field("timer_reset", e.timer_reset, got.timer_reset);
        field("persist_needed", e.persist_needed, got.persist_needed);
        field("commit_index", e.commit_index, got.commit_index);
        field("overflow", e.overflow, got.overflow);
    endtask

    initial begin
        failures = 0;
        stored_len = 1;
        base_idx = '0;
        base_term = '0;
        cur_term = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_idx = '0;
            base_term = '0;
            cur_term = '0;
            vote_valid = 0;
            voted_id = '0;
            stored_len = 1;
            commit = '0;
            left = 0;
            batch_ok = 0;
            slot = 0;
            pend_commit = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_BASE_INDEX)
                    base_idx = i_cfg_data;
                else if (i_cfg_idx == REG_BASE_TERM)
                    base_term = i_cfg_data;
            end
            if (reply.valid && reply.ready)
                check_reply(reply.data);
            if (msg.valid && msg.ready)
                if (predict_reply(msg.data, predicted))
                    replies_due = {replies_due, predicted};
        end
        o_term = cur_term;
        o_last_term = term_of(longint'(stored_len) - 1);
        o_log_end = log_end();
        o_failures = failures;
        o_pending = replies_due.size();
    end

endmodule

FILE: bench/raft_vote_and_append_receiver_test.sv
module raft_vote_and_append_receiver_test;
    import rvar_pkg::*;

    localparam int                WATCHDOG = 5000;
    localparam int                DEPTH    = LOG_DEPTH_DEF;
    localparam logic [TERM_W-1:0] M31      = {TERM_W{1'b1}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [TERM_W-1:0]    cfg_data;
    logic [TERM_W-1:0]    chk_term, chk_last_term;
    longint               chk_log_end;
    int                   chk_failures, chk_pending;

    int                   idle_pct, stall_pct, quiet, n_sent;
    bit                   hold_req;
    logic [TERM_W-1:0]    base_now;

    rvar_in_if  msg_if ();
    rvar_out_if reply_if ();

    raft_vote_and_append_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_msg      (msg_if),
        .o_reply    (reply_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    raft_vote_and_append_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .msg         (msg_if),
        .reply       (reply_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_term      (chk_term),
        .o_last_term (chk_last_term),
        .o_log_end   (chk_log_end),
        .o_failures  (chk_failures),
        .o_pending   (chk_pending)
    );

    initial i_clk = 0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((msg_if.valid && msg_if.ready) || (reply_if.valid && reply_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        reply_if.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                reply_if.ready <= 0;
                repeat (400) @(negedge i_clk);
            end
            reply_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_in_item item(input t_mode md, input logic [TERM_W-1:0] mt,
                                      input logic [ID_W-1:0] sid,
                                      input logic [TERM_W-1:0] li, lt, lc,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic [TERM_W-1:0] et);
        t_in_item m;
        m.mode = md;
        m.msg_term = mt;
        m.sender_id = sid;
        m.log_index = li;
        m.log_term = lt;
        m.leader_commit = lc;
        m.entry_count = cnt;
        m.entry_term = et;
        return m;
    endfunction

    function automatic logic [TERM_W-1:0] rnd31();
        return TERM_W'($urandom());
    endfunction

    function automatic logic [ID_W-1:0] rnd_id();
        return ID_W'($urandom_range(15));
    endfunction

    function automatic logic [CNT_W-1:0] rnd_cnt();
        return CNT_W'($urandom_range(127));
    endfunction

    function automatic logic [TERM_W-1:0] last_index();
        return (chk_log_end - 1 > longint'(M31)) ? M31 : TERM_W'(chk_log_end - 1);
    endfunction

    function automatic logic [TERM_W-1:0] pick_term();
        int r;
        r = $urandom_range(99);
        if (r < 8 && chk_term < M31)
            return chk_term + TERM_W'(1);
        if (r < 12 && chk_term > 0)
            return chk_term - TERM_W'(1);
        return chk_term;
    endfunction

    task automatic send(input t_in_item m);
        while ($urandom_range(99) < idle_pct) begin
            msg_if.valid <= 0;
            @(negedge i_clk);
        end
        msg_if.valid <= 1;
        msg_if.data <= m;
        @(posedge i_clk);
        while (!msg_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (m.mode != MODE_NONE)
            n_sent++;
    endtask

    task automatic drain();
        msg_if.valid <= 0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_base(input logic [TERM_W-1:0] idx, input logic [TERM_W-1:0] term);
        cfg_we <= 1;
        cfg_idx <= REG_BASE_INDEX;
        cfg_data <= idx;
        @(negedge i_clk);
        cfg_idx <= REG_BASE_TERM;
        cfg_data <= term;
        @(negedge i_clk);
        cfg_we <= 0;
        base_now = idx;
        @(negedge i_clk);
    endtask

    task automatic send_vote();
        logic [TERM_W-1:0] mt, li, lt;
        int                r;
        mt = pick_term();
        r = $urandom_range(99);
        lt = chk_last_term;
        if (r < 15 && lt < M31)
            lt = lt + TERM_W'(1);
        else if (r < 30 && lt > 0)
            lt = lt - TERM_W'(1);
        else if (r < 40)
            lt = rnd31();
        li = last_index();
        r = $urandom_range(99);
        if (r < 20 && li < M31)
            li = li + TERM_W'(1);
        else if (r < 40 && li > 0)
            li = li - TERM_W'(1);
        else if (r < 50)
            li = rnd31();
        send(item(MODE_VOTE, mt, rnd_id(), li, lt, rnd31(), rnd_cnt(), rnd31()));
    endtask

    task automatic send_batch(input bit broken);
        logic [TERM_W-1:0] mt, li, lt, lc, last, et;
        logic [CNT_W-1:0]  cnt;
        int                r, n_ent;
        mt = pick_term();
        last = last_index();
        r = $urandom_range(99);
        if (r < 65)
            li = last;
        else if (r < 85)
            li = TERM_W'($urandom_range(last, base_now));
        else if (r < 90 && base_now > 0)
            li = TERM_W'($urandom_range(base_now - TERM_W'(1), 0));
        else if (r < 95)
            li = (last < M31 - TERM_W'(5)) ? last + TERM_W'($urandom_range(5, 1)) : M31;
        else
            li = rnd31();
        if (li == last && $urandom_range(99) < 85)
            lt = chk_last_term;
        else
            lt = TERM_W'($urandom_range(chk_term,
                                         (chk_term > 3) ? chk_term - TERM_W'(3) : '0));
        r = $urandom_range(99);
        if (r < 10)
            cnt = 7'd0;
        else if (r < 15)
            cnt = 7'd64;
        else if (r < 18)
            cnt = CNT_W'($urandom_range(127, 65));
        else
            cnt = CNT_W'($urandom_range(12, 1));
        r = $urandom_range(99);
        if (r < 50)
            lc = last;
        else if (r < 80)
            lc = TERM_W'($urandom_range(last, 0));
        else
            lc = rnd31();
        send(item(MODE_HDR, mt, rnd_id(), li, lt, lc, cnt, rnd31()));
        n_ent = (int'(cnt) > 64) ? 64 : int'(cnt);
        if (broken && n_ent > 0)
            n_ent = int'($urandom_range(n_ent - 1, 0));
        repeat (n_ent) begin
            et = ($urandom_range(99) < 80) ? mt : TERM_W'($urandom_range(mt, 0));
            send(item(MODE_ENTRY, rnd31(), rnd_id(), rnd31(), rnd31(), rnd31(),
                      rnd_cnt(), et));
        end
    endtask

    task automatic random_traffic(input int n);
        int r, stop;
        stop = n_sent + n;
        while (n_sent < stop) begin
            r = $urandom_range(99);
            if (r < 25)
                send_vote();
            else if (r < 85)
                send_batch(0);
            else if (r < 92)
                send(item(($urandom_range(1) == 0) ? MODE_NONE : MODE_ENTRY, rnd31(),
                          rnd_id(), rnd31(), rnd31(), rnd31(), rnd_cnt(), rnd31()));
            else
                send_batch(1);
        end
    endtask

    task automatic fill_store();
        int guard;
        guard = 0;
        // one more batch than needed, so the last one overflows
        while (guard < 20) begin
            send(item(MODE_HDR, chk_term, 4'd1, last_index(), chk_last_term, last_index(),
                      7'd64, '0));
            repeat (64)
                send(item(MODE_ENTRY, '0, 4'd1, '0, '0, '0, '0, chk_term));
            guard++;
            if (chk_log_end - longint'(base_now) >= DEPTH)
                guard = 20;
        end
        send(item(MODE_HDR, chk_term, 4'd1, last_index(), chk_last_term, last_index(),
                  7'd64, '0));
        repeat (64)
            send(item(MODE_ENTRY, '0, 4'd1, '0, '0, '0, '0, chk_term));
    endtask

    initial begin
        i_rst_n = 0;
        msg_if.valid = 0;
        msg_if.data = '0;
        cfg_we = 0;
        cfg_idx = '0;
        cfg_data = '0;
        quiet = 0;
        n_sent = 0;
        hold_req = 0;
        idle_pct = 0;
        stall_pct = 0;
        base_now = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        set_base('0, '0);

        send(item(MODE_VOTE, 0, 0, 0, 0, 0, 0, 0));
        send(item(MODE_VOTE, 0, 1, 0, 0, 0, 0, 0));
        send(item(MODE_VOTE, 1, 2, 0, 0, 0, 0, 0));
        send(item(MODE_VOTE, 0, 3, 5, 5, 0, 0, 0));
        send(item(MODE_HDR, 1, 2, 0, 0, 0, 0, 0));
        send(item(MODE_HDR, 1, 2, 0, 0, 1, 3, 0));
        repeat (3) send(item(MODE_ENTRY, 0, 2, 0, 0, 0, 0, 1));
        send(item(MODE_HDR, 1, 2, 9, 1, 0, 0, 0));
        send(item(MODE_HDR, 2, 4, 3, 0, 0, 0, 0));
        send(item(MODE_HDR, 1, 2, 3, 1, 3, 2, 0));
        repeat (2) send(item(MODE_ENTRY, 0, 2, 0, 0, 0, 0, 7));
        send(item(MODE_HDR, 2, 4, 3, 1, 3, 2, 0));
        send(item(MODE_ENTRY, 0, 4, 0, 0, 0, 0, 2));
        send(item(MODE_VOTE, 2, 3, 9, 9, 0, 0, 0));
        send(item(MODE_ENTRY, 0, 4, 0, 0, 0, 0, 2));
        send(item(MODE_NONE, M31, 4'd15, M31, M31, M31, 7'd127, M31));
        send(item(MODE_HDR, 2, 4, 1, 1, 0, 1, 0));
        send(item(MODE_ENTRY, 0, 4, 0, 0, 0, 0, 2));
        send(item(MODE_VOTE, 2, 3, 2, 2, 0, 0, 0));
        drain();

        set_base(TERM_W'(5), TERM_W'(1));
        fill_store();
        random_traffic(100);
        drain();

        idle_pct = 45;
        stall_pct = 0;
        set_base(TERM_W'(3), TERM_W'(2));
        hold_req = 1;
        random_traffic(300);
        drain();

        idle_pct = 0;
        stall_pct = 45;
        set_base(TERM_W'($urandom_range(1000)), TERM_W'($urandom_range(chk_term)));
        random_traffic(300);
        drain();

        idle_pct = 34;
        stall_pct = 34;
        set_base(M31 - TERM_W'(3), TERM_W'(7));
        random_traffic(300);
        drain();

        idle_pct = 0;
        stall_pct = 0;
        set_base(M31, M31);
        send(item(MODE_VOTE, M31, 4'd15, M31, M31, M31, 7'd0, M31));
        send(item(MODE_HDR, M31, 4'd15, M31, M31, M31, 7'd1, '0));
        send(item(MODE_ENTRY, M31, 4'd15, M31, M31, M31, 7'd127, M31));
        send(item(MODE_HDR, M31, 4'd0, M31 - TERM_W'(1), '0, M31, 7'd0, '0));
        send(item(MODE_VOTE, 0, 0, 0, 0, 0, 0, 0));
        drain();
        repeat (20) @(negedge i_clk);

        if (chk_failures == 0 && chk_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
